// File: rtl/dcp_pkg.sv
// dcp_pkg: request types, result codes and DSI data type codes of the command packetizer.
// No dependencies; imported by every module of the block.
package dcp_pkg;

  // Default payload limit of a long write, in bytes.
  localparam int MAX_PAYLOAD_DEF = 256;

  // Result queue depth. It must stay a power of two and at least 4.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_TYPE  = 3'd1;
  localparam logic [2:0] ERR_SIZE  = 3'd2;
  localparam logic [2:0] ERR_EMPTY = 3'd3;
  localparam logic [2:0] ERR_LONG  = 3'd4;

  // DSI data types.
  localparam logic [5:0] DT_GEN_SW0   = 6'h03;
  localparam logic [5:0] DT_GEN_SW1   = 6'h13;
  localparam logic [5:0] DT_GEN_SW2   = 6'h23;
  localparam logic [5:0] DT_MAX_RET   = 6'h37;
  localparam logic [5:0] DT_GEN_RD0   = 6'h04;
  localparam logic [5:0] DT_GEN_RD1   = 6'h14;
  localparam logic [5:0] DT_GEN_RD2   = 6'h24;
  localparam logic [5:0] DT_DCS_RD    = 6'h06;
  localparam logic [5:0] DT_DCS_SW0   = 6'h05;
  localparam logic [5:0] DT_DCS_SW1   = 6'h15;
  localparam logic [5:0] DT_GEN_LONG  = 6'h29;
  localparam logic [5:0] DT_DCS_LONG  = 6'h39;

  typedef struct packed {
    logic [5:0]  cmd_type;
    logic [1:0]  virtual_channel;
    logic        has_byte;
    logic [7:0]  payload_byte;
    logic        end_of_command;
    logic [15:0] response_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic        bta_request;
    logic [2:0]  error_code;
    logic        last;
  } out_item_t;

  // Results of one request handed to the queue: count (0..2) and the entries.
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } res_push_t;

  function automatic out_item_t mk_item(input logic [1:0] kind, input logic [31:0] word,
                                        input logic bta, input logic [2:0] err,
                                        input logic last);
    out_item_t it;
    it.kind        = kind;
    it.word        = word;
    it.bta_request = bta;
    it.error_code  = err;
    it.last        = last;
    return it;
  endfunction

endpackage

// File: rtl/dcp_core.sv
// dcp_core: packing state (byte count, word assembly, short bytes) and result decode.
// Depends on dcp_pkg.
module dcp_core #(
  parameter int MAX_PAYLOAD_BYTES = dcp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  dcp_pkg::in_item_t   item,
  output dcp_pkg::res_push_t  push
);
  import dcp_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_PAYLOAD_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [23:0]      word_asm_r, word_asm_nxt;
  logic [15:0]      short_bytes_r, short_bytes_nxt;

  logic [31:0] full_word;
  logic        word_done;
  logic        is_long;
  logic [2:0]  err;
  logic        bta;
  logic [31:0] hdr;
  logic [31:0] cnt_ext;

  always_comb begin
    byte_count_nxt  = byte_count_r;
    word_asm_nxt    = word_asm_r;
    short_bytes_nxt = short_bytes_r;
    full_word       = '0;
    word_done       = 1'b0;

    if (item.has_byte) begin
      if (byte_count_r < CNT_MAX) begin
        if (byte_count_r < CNT_TWO) begin
          if (byte_count_r[0]) short_bytes_nxt[15:8] = item.payload_byte;
          else                 short_bytes_nxt[7:0]  = item.payload_byte;
        end
        case (byte_count_r[1:0])
          2'd0: word_asm_nxt[7:0]   = item.payload_byte;
          2'd1: word_asm_nxt[15:8]  = item.payload_byte;
          2'd2: word_asm_nxt[23:16] = item.payload_byte;
          default: begin
            full_word    = {item.payload_byte, word_asm_r};
            word_asm_nxt = '0;
            word_done    = 1'b1;
          end
        endcase
        byte_count_nxt = byte_count_r + CNT_ONE;
      end else begin
        // drop bytes past the limit and mark the overflow
        byte_count_nxt = CNT_SAT;
      end
    end

    is_long = (item.cmd_type == DT_GEN_LONG) || (item.cmd_type == DT_DCS_LONG);

    err = ERR_NONE;
    bta = 1'b0;
    case (item.cmd_type)
      DT_GEN_SW0, DT_GEN_SW1, DT_GEN_SW2, DT_MAX_RET: begin
        if (byte_count_nxt > CNT_TWO) err = ERR_SIZE;
      end
      DT_GEN_LONG, DT_DCS_LONG: begin
        if (byte_count_nxt > CNT_MAX) err = ERR_LONG;
      end
      DT_GEN_RD0, DT_GEN_RD1, DT_GEN_RD2, DT_DCS_RD: begin
        if (byte_count_nxt > CNT_TWO)          err = ERR_SIZE;
        else if (item.response_length == '0)   err = ERR_EMPTY;
        else                                   bta = 1'b1;
      end
      DT_DCS_SW0, DT_DCS_SW1: begin
        if (byte_count_nxt != CNT_ONE && byte_count_nxt != CNT_TWO) err = ERR_SIZE;
      end
      default: err = ERR_TYPE;
    endcase

    cnt_ext = 32'(byte_count_nxt);
    hdr     = {16'h0000, 8'h00, item.virtual_channel, item.cmd_type};
    if (is_long) begin
      hdr[15:8]  = cnt_ext[7:0];
      hdr[23:16] = cnt_ext[15:8];
    end else begin
      if (byte_count_nxt >= CNT_ONE) hdr[15:8]  = short_bytes_nxt[7:0];
      if (byte_count_nxt == CNT_TWO) hdr[23:16] = short_bytes_nxt[15:8];
    end

    push.n  = 2'd0;
    push.r0 = mk_item(KIND_PAYLOAD, full_word, 1'b0, ERR_NONE, 1'b0);
    push.r1 = mk_item(KIND_HEADER, hdr, 1'b0, ERR_NONE, 1'b1);
    if (item_valid) begin
      if (!item.end_of_command) begin
        if (word_done && is_long) push.n = 2'd1;
      end else if (err != ERR_NONE) begin
        push.n  = 2'd1;
        push.r0 = mk_item(KIND_ERROR, 32'h0, 1'b0, err, 1'b1);
      end else if (is_long) begin
        if (word_done) begin
          push.n = 2'd2;
        end else if (byte_count_nxt[1:0] != 2'd0) begin
          push.n  = 2'd2;
          push.r0 = mk_item(KIND_PAYLOAD, {8'h00, word_asm_nxt}, 1'b0, ERR_NONE, 1'b0);
        end else begin
          push.n  = 2'd1;
          push.r0 = mk_item(KIND_HEADER, hdr, 1'b0, ERR_NONE, 1'b1);
        end
      end else begin
        push.n  = 2'd1;
        push.r0 = mk_item(KIND_HEADER, hdr, bta, ERR_NONE, 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      word_asm_r    <= '0;
      short_bytes_r <= '0;
    end else if (item_valid) begin
      if (item.end_of_command) begin
        byte_count_r  <= '0;
        word_asm_r    <= '0;
        short_bytes_r <= '0;
      end else begin
        byte_count_r  <= byte_count_nxt;
        word_asm_r    <= word_asm_nxt;
        short_bytes_r <= short_bytes_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item.end_of_command |=> byte_count_r == '0 && word_asm_r == '0)
    else $error("packing state not cleared after final request");

  a_two_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> item_valid && item.end_of_command && push.r1.last)
    else $error("two results outside a final request");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CNT_SAT)
    else $error("byte count beyond saturation value");
`endif

endmodule

// File: rtl/dcp_outq.sv
// dcp_outq: small result queue, takes up to two results a cycle, delivers one if not stalled.
// Depends on dcp_pkg.
module dcp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  dcp_pkg::res_push_t  push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output dcp_pkg::out_item_t  out_data
);
  import dcp_pkg::*;

  localparam int CW = QAW + 1;

  out_item_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW-1:0]   wr_ptr_inc;
  logic [CW-1:0]    count_r, count_nxt;
  logic             pop;

  assign out_valid  = (count_r != '0);
  assign out_data   = mem_r[rd_ptr_r];
  assign pop        = out_valid && !out_stall;
  assign room       = (count_r <= CW'(QDEPTH - 2));
  assign wr_ptr_inc = wr_ptr_r + QAW'(1);
  assign count_nxt  = count_r + CW'(push.n) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r]   <= push.r0;
    if (push.n == 2'd2) mem_r[wr_ptr_inc] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QAW'(push.n);
      if (pop) rd_ptr_r <= rd_ptr_r + QAW'(1);
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QDEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> room)
    else $error("push without room");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |=> out_valid)
    else $error("pushed result not presented");
`endif

endmodule

// File: rtl/dsi_command_packetizer_unit.sv
// dsi_command_packetizer_unit: top level of the DSI command packetizer.
// Depends on dcp_pkg, dcp_core and dcp_outq.
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_valid/in_stall   | dcp_pkg::in_item_t  (one payload byte)
//  out_    | result    | out_valid/out_stall | dcp_pkg::out_item_t (payload, header, error)
//
// One request per cycle is taken when results drain freely; each request passes through
// the input register, then its results land in a four-entry result queue.
// A final request may produce two results (last partial word plus header), delivered one
// per cycle while out_stall is low, so the queue drain rate sets sustained throughput.
// Reset is synchronous, active low, and clears the packing state and the queue.
// in_stall rises only when the request held in the input register cannot hand off its
// results because the queue has fewer than two free entries.
module dsi_command_packetizer_unit #(
  parameter int MAX_PAYLOAD_BYTES = dcp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dcp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dcp_pkg::out_item_t out_data
);
  import dcp_pkg::*;

  // Input register: holds one request until the queue can take its results.
  logic      stage_valid_r;
  in_item_t  stage_item_r;
  logic      room;
  logic      advance;
  logic      load;
  res_push_t push;

  assign advance  = stage_valid_r && room;
  assign in_stall = stage_valid_r && !room;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (load) begin
      stage_valid_r <= 1'b1;
    end else if (advance) begin
      stage_valid_r <= 1'b0;
    end
  end

  // Payload register needs no reset; it is qualified by stage_valid_r.
  always_ff @(posedge clk) begin
    if (load) stage_item_r <= in_data;
  end

  // Packing state and result decode; state advances when the request moves on.
  dcp_core #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (advance),
    .item       (stage_item_r),
    .push       (push)
  );

  // Result register stage: a small queue decouples result stalls from the input side.
  dcp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_valid_r && !room)
    else $error("input stalled with empty input register");

  a_held_request_moves: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && room && !load |=> !stage_valid_r)
    else $error("advanced request still held");

  a_load_sets_stage: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> stage_valid_r)
    else $error("accepted request not registered");
`endif

endmodule
